// ===== hw/rtl/fdst_pkg.sv =====
// Shared constants for the frame difference spot tracker.
// No dependencies; imported by the tracker top level.
package fdst_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 9;
  localparam int COL_W = 10;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd30;

endpackage

// ===== hw/rtl/frame_diff_spot_tracker.sv =====
// Frame difference spot tracker: the result register loads as stage 1 advances with
// the end-of-frame pixel (store read at accept, compare and result register next).
// Throughput one pixel per cycle with forwarding for a back-to-back same-entry access; an
// end-of-frame pixel holds stage 1, and so the input, while the previous word waits.
// Reset clears pipeline valids, the bounding box, the reference flag and sets the
// threshold to 30; the frame store is not cleared (first frame fills it).
// Depends on fdst_pkg and fdst_ram.
module frame_diff_spot_tracker
  import fdst_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  // configuration write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PIX_W-1:0] diff_threshold,
  // pixel stream
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pixel_value,
  input  logic [ROW_W-1:0] pixel_row,
  input  logic [COL_W-1:0] pixel_col,
  input  logic             end_of_frame,
  // result stream
  output logic             out_valid,
  input  logic             out_ready,
  output logic             spot_found,
  output logic [COL_W-1:0] centre_x,
  output logic [ROW_W-1:0] centre_y,
  output logic [COL_W-1:0] box_left,
  output logic [COL_W-1:0] box_right,
  output logic [ROW_W-1:0] box_top,
  output logic [ROW_W-1:0] box_bottom
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [AddrW-1:0] addr;
    logic             in_range;
    logic             eof;
  } stage_t;

  logic [PIX_W-1:0] thresh;

  // stage 1 (memory data valid)
  logic             s1_valid;
  stage_t           s1;
  logic             fwd_hit;
  logic [PIX_W-1:0] fwd_data;

  // bounding box state
  logic             ref_ready;
  logic             any_marked;
  logic [COL_W-1:0] min_col, max_col;
  logic [ROW_W-1:0] min_row, max_row;

  logic             accept;
  logic             s1_adv;
  stage_t           in_word;
  logic [31:0]      addr_full;
  logic [PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0] old_pix;
  logic [PIX_W-1:0] diff;
  logic             mark;
  logic             any_next;
  logic [COL_W-1:0] min_col_next, max_col_next;
  logic [ROW_W-1:0] min_row_next, max_row_next;
  logic [COL_W:0]   sum_x;
  logic [ROW_W:0]   sum_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= diff_threshold;
    end
  end

  // input word and store address
  assign addr_full = 32'(pixel_row) * 32'(MAX_WIDTH) + 32'(pixel_col);

  always_comb begin
    in_word.pix      = pixel_value;
    in_word.row      = pixel_row;
    in_word.col      = pixel_col;
    in_word.addr     = addr_full[AddrW-1:0];
    in_word.in_range = (32'(pixel_row) < 32'(MAX_HEIGHT)) &&
                       (32'(pixel_col) < 32'(MAX_WIDTH));
    in_word.eof      = end_of_frame;
  end

  // stall stage 1 only when it carries end of frame and the full result slot is not read
  assign s1_adv   = s1_valid && (!s1.eof || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  fdst_ram #(
    .WIDTH(PIX_W),
    .DEPTH(Depth),
    .AW   (AddrW)
  ) u_store (
    .clk  (clk),
    .we   (s1_adv && s1.in_range),
    .waddr(s1.addr),
    .wdata(s1.pix),
    .re   (accept && in_word.in_range),
    .raddr(in_word.addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // capture the word and forward a write to the same entry in the accept cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= in_word;
      fwd_hit  <= s1_adv && s1.in_range && (s1.addr == in_word.addr);
      fwd_data <= s1.pix;
    end
  end

  assign old_pix = fwd_hit ? fwd_data : ram_rdata;
  assign diff    = (s1.pix > old_pix) ? (s1.pix - old_pix) : '0;
  assign mark    = ref_ready && s1.in_range && (diff > thresh);

  always_comb begin
    any_next     = any_marked;
    min_col_next = min_col;
    max_col_next = max_col;
    min_row_next = min_row;
    max_row_next = max_row;
    if (mark) begin
      any_next = 1'b1;
      if (s1.col < min_col) min_col_next = s1.col;
      if (s1.col > max_col) max_col_next = s1.col;
      if (s1.row < min_row) min_row_next = s1.row;
      if (s1.row > max_row) max_row_next = s1.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_ready  <= 1'b0;
      any_marked <= 1'b0;
      min_col    <= '1;
      max_col    <= '0;
      min_row    <= '1;
      max_row    <= '0;
    end else if (s1_adv) begin
      if (s1.eof) begin
        // close the frame: clear the box and set the reference flag
        ref_ready  <= 1'b1;
        any_marked <= 1'b0;
        min_col    <= '1;
        max_col    <= '0;
        min_row    <= '1;
        max_row    <= '0;
      end else begin
        any_marked <= any_next;
        min_col    <= min_col_next;
        max_col    <= max_col_next;
        min_row    <= min_row_next;
        max_row    <= max_row_next;
      end
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.eof) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.eof) begin
      spot_found <= any_next;
      box_left   <= any_next ? min_col_next : '0;
      box_right  <= any_next ? max_col_next : '0;
      box_top    <= any_next ? min_row_next : '0;
      box_bottom <= any_next ? max_row_next : '0;
    end
  end

  // min + (max - min) / 2 equals the floored mean since max >= min
  assign sum_x    = {1'b0, box_left} + {1'b0, box_right};
  assign sum_y    = {1'b0, box_top} + {1'b0, box_bottom};
  assign centre_x = sum_x[COL_W:1];
  assign centre_y = sum_y[ROW_W:1];

  a_no_spot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !spot_found |-> box_left == '0 && box_right == '0 &&
                                 box_top == '0 && box_bottom == '0)
    else $error("empty result carries a nonzero box");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && spot_found |-> box_left <= box_right && box_top <= box_bottom)
    else $error("reported box is inverted");

  a_clear_after_eof: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.eof |=> !any_marked && ref_ready)
    else $error("box not cleared at end of frame");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !in_ready)
    else $error("pixel accepted while stage 1 is stalled");

endmodule

// ===== hw/rtl/fdst_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address being written in the same cycle returns the old data.
// No dependencies.
module fdst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for frame_diff_spot_tracker: pixel frames in, bounding box words out.
// Holds its own frame store and box predictor; depends on fdst_pkg and the tracker RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdst_pkg::*;

  localparam int POOL_SIZE    = 32;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 300000;
  localparam int PHASE_PIXELS = 100;

  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] cy;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
  } box_word_t;

  class frame_box_tracker;
    logic [PIX_W-1:0] stored [bit [ROW_W+COL_W-1:0]];
    logic [PIX_W-1:0] threshold;
    bit               ref_ready;
    bit               any_marked;
    logic [COL_W-1:0] min_col, max_col;
    logic [ROW_W-1:0] min_row, max_row;
    box_word_t        pending_boxes[$];
    int               mismatches;
    int               frames_closed;
    int               spot_frames;

    function new();
      threshold = THRESH_RESET;
      ref_ready = 0;
      clear_box();
    endfunction

    function void clear_box();
      any_marked = 0;
      min_col = '1;
      max_col = '0;
      min_row = '1;
      max_row = '0;
    endfunction

    function logic [PIX_W-1:0] stored_at(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      return stored.exists({row, col}) ? stored[{row, col}] : '0;
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col, logic eof);
      int unsigned diff;
      box_word_t   w;
      if (row < DEF_MAX_HEIGHT && col < DEF_MAX_WIDTH) begin
        diff = (pix > stored_at(row, col)) ? pix - stored_at(row, col) : 0;
        if (ref_ready && diff > threshold) begin
          any_marked = 1;
          if (col < min_col) min_col = col;
          if (col > max_col) max_col = col;
          if (row < min_row) min_row = row;
          if (row > max_row) max_row = row;
        end
        stored[{row, col}] = pix;
      end
      if (eof) begin
        w = '0;
        if (any_marked) begin
          w.found  = 1;
          w.cx     = COL_W'(min_col + (max_col - min_col) / 2);
          w.cy     = ROW_W'(min_row + (max_row - min_row) / 2);
          w.left   = min_col;
          w.right  = max_col;
          w.top    = min_row;
          w.bottom = max_row;
          spot_frames++;
        end
        pending_boxes.push_back(w);
        frames_closed++;
        ref_ready = 1;
        clear_box();
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_box(box_word_t got);
      box_word_t exp_w;
      if (pending_boxes.size() == 0) begin
        $error("result word with no frame closed");
        mismatches++;
        return;
      end
      exp_w = pending_boxes.pop_front();
      compare_field("spot_found", exp_w.found, got.found);
      compare_field("centre_x", exp_w.cx, got.cx);
      compare_field("centre_y", exp_w.cy, got.cy);
      compare_field("box_left", exp_w.left, got.left);
      compare_field("box_right", exp_w.right, got.right);
      compare_field("box_top", exp_w.top, got.top);
      compare_field("box_bottom", exp_w.bottom, got.bottom);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [PIX_W-1:0] diff_threshold;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] pixel_value;
  logic [ROW_W-1:0] pixel_row;
  logic [COL_W-1:0] pixel_col;
  logic             end_of_frame;
  logic             out_valid;
  logic             out_ready;
  logic             spot_found;
  logic [COL_W-1:0] centre_x;
  logic [ROW_W-1:0] centre_y;
  logic [COL_W-1:0] box_left;
  logic [COL_W-1:0] box_right;
  logic [ROW_W-1:0] box_top;
  logic [ROW_W-1:0] box_bottom;

  frame_box_tracker tracker = new();

  logic [ROW_W-1:0] pool_row [POOL_SIZE];
  logic [COL_W-1:0] pool_col [POOL_SIZE];
  int               burst_left = 0;
  int               pixels_sent = 0;
  int               threshold_writes = 0;

  frame_diff_spot_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .diff_threshold(diff_threshold),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_value   (pixel_value),
    .pixel_row     (pixel_row),
    .pixel_col     (pixel_col),
    .end_of_frame  (end_of_frame),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .spot_found    (spot_found),
    .centre_x      (centre_x),
    .centre_y      (centre_y),
    .box_left      (box_left),
    .box_right     (box_right),
    .box_top       (box_top),
    .box_bottom    (box_bottom)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Accepted words of all three channels, seen in one place at the edge.
  always @(posedge clk) begin
    box_word_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.threshold = diff_threshold;
      if (in_valid && in_ready)
        tracker.take_pixel(pixel_value, pixel_row, pixel_col, end_of_frame);
      if (out_valid === 1'b1 && out_ready) begin
        got = '{spot_found, centre_x, centre_y, box_left, box_right, box_top, box_bottom};
        tracker.check_box(got);
      end
    end
  end

  // Receiver: stretches of always-ready, coin-flip, sparse and long-stall behavior.
  initial begin
    int mode;
    int len;
    out_ready = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 80);
      for (int k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = (k >= len - 3);
        endcase
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_value(logic [PIX_W-1:0] old_v,
                                                  logic [PIX_W-1:0] thr);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 255);
      4, 5, 6:    v = old_v + thr + 1 + $urandom_range(0, 8);
      7:          v = old_v;
      8:          v = old_v + thr;
      default:    v = $urandom_range(0, old_v);
    endcase
    return (v > 255) ? 8'd255 : v[PIX_W-1:0];
  endfunction

  // Send one pixel word; with auto_value the grey level is picked against the stored one.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit auto_value,
                            input int idx, input bit eof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 0;
        repeat (gap) @(posedge clk);
      end
    end
    @(negedge clk);
    if (auto_value)
      pix = pick_value(tracker.stored_at(pool_row[idx], pool_col[idx]), tracker.threshold);
    in_valid     = 1;
    pixel_value  = pix;
    pixel_row    = pool_row[idx];
    pixel_col    = pool_col[idx];
    end_of_frame = eof;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 0;
    while (tracker.pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [PIX_W-1:0] thr);
    wait_drained();
    @(negedge clk);
    cfg_valid      = 1;
    diff_threshold = thr;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    threshold_writes++;
  endtask

  // Frames built only from pool locations, so every read hits a written entry.
  task automatic run_frames(input int pixels_wanted);
    int sent;
    int len;
    int idx;
    int prev_idx;
    sent     = 0;
    prev_idx = 0;
    while (sent < pixels_wanted) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        idx = ($urandom_range(0, 6) == 0) ? prev_idx : $urandom_range(0, POOL_SIZE - 1);
        send_pixel('0, 1, idx, k == len - 1);
        prev_idx = idx;
        sent++;
      end
    end
  endtask

  initial begin
    logic [PIX_W-1:0] phase_thr [6];
    rst            = 1;
    cfg_valid      = 0;
    diff_threshold = '0;
    in_valid       = 0;
    pixel_value    = '0;
    pixel_row      = '0;
    pixel_col      = '0;
    end_of_frame   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Corners first, then random locations.
    pool_row[0] = 9'd0;   pool_col[0] = 10'd0;
    pool_row[1] = 9'd0;   pool_col[1] = 10'd1023;
    pool_row[2] = 9'd511; pool_col[2] = 10'd0;
    pool_row[3] = 9'd511; pool_col[3] = 10'd1023;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_row[i] = ROW_W'($urandom_range(0, 511));
      pool_col[i] = COL_W'($urandom_range(0, 1023));
    end

    // First frame fills the store and must report no spot.
    for (int i = 0; i < POOL_SIZE; i++)
      send_pixel((i < 4) ? 8'd0 : 8'($urandom_range(0, 255)), 0, i, i == POOL_SIZE - 1);
    // Full-size box across all four extremes.
    send_pixel(8'd255, 0, 0, 0);
    send_pixel(8'd255, 0, 3, 1);
    // Same value again: no difference, no spot.
    send_pixel(8'd255, 0, 0, 1);
    // Negative difference clamps to zero; one above threshold marks.
    send_pixel(8'd0, 0, 0, 0);
    send_pixel(8'd31, 0, 1, 1);
    // Exactly at threshold stays unmarked.
    send_pixel(8'd30, 0, 2, 1);
    // Two successive pixels at one location; a random gap may fall between them.
    send_pixel(8'd0, 0, 2, 0);
    send_pixel(8'd200, 0, 2, 1);
    wait_drained();

    phase_thr[0] = 8'd0;
    phase_thr[1] = 8'd255;
    phase_thr[2] = PIX_W'($urandom_range(1, 254));
    phase_thr[3] = THRESH_RESET;
    phase_thr[4] = PIX_W'($urandom_range(1, 254));
    phase_thr[5] = 8'd128;
    foreach (phase_thr[p]) begin
      write_threshold(phase_thr[p]);
      run_frames(PHASE_PIXELS);
    end
    wait_drained();

    $display("covered %0d pixels in %0d frames, %0d of them with a spot",
             pixels_sent, tracker.frames_closed, tracker.spot_frames);
    $display("threshold written %0d times, zero and full scale among the settings",
             threshold_writes);
    if (tracker.mismatches == 0 && tracker.pending_boxes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
